// ----- rtl/core/ldags_pkg.sv -----
// Shared types, sizes and helpers for the LDA Gibbs topic sampler.
// Used by every module of the block; depends on nothing.
package ldags_pkg;

  localparam int VOCABULARY = 4096;
  localparam int TOPICS     = 16;
  localparam int MAX_WORDS  = 64;

  localparam int WORD_W   = $clog2(VOCABULARY);
  localparam int TOPIC_W  = $clog2(TOPICS);
  localparam int POS_W    = $clog2(MAX_WORDS);
  localparam int CNT_W    = 7;
  localparam int MODEL_W  = 24;
  localparam int TOTAL_W  = 32;
  localparam int FIX_W    = 24;
  localparam int FRAC     = 16;
  localparam int WT_W     = 32;
  localparam int THETA_W  = 16;
  // (n+s)<<16 plus beta, and (T+d)<<16 plus V*beta
  localparam int NUM_W    = MODEL_W + 1 + FRAC + 1;
  localparam int DEN_W    = TOTAL_W + 1 + FRAC + 1;
  localparam int DFAC_W   = FIX_W + 1;
  localparam int PROD_W   = WT_W + DFAC_W;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    KIND_LOAD_COUNT = 3'd0,
    KIND_LOAD_TOTAL = 3'd1,
    KIND_ADD        = 3'd2,
    KIND_RESAMPLE   = 3'd3,
    KIND_THETA      = 3'd4,
    KIND_CLEAR      = 3'd5
  } kind_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [11:0]        word_id;
    logic [5:0]         local_word;
    logic [5:0]         position;
    logic [3:0]         topic;
    logic [31:0]        count;
    logic [15:0]        random_u;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         new_topic;
    logic [15:0]        theta_q16;
    logic               is_theta;
  } out_item_t;

  typedef logic [TOPICS-1:0][CNT_W-1:0] row_t;

  typedef struct packed {
    logic [TOPIC_W-1:0] topic;
    logic [WORD_W-1:0]  word;
    logic [POS_W-1:0]   loc;
  } pos_ent_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_WR,
    S_RS_ROW,
    S_RS_DEC,
    S_RS_RD,
    S_RS_DIV,
    S_RS_WAIT,
    S_RS_MUL,
    S_RS_ACC,
    S_RS_THR,
    S_RS_SCAN,
    S_RS_ADD,
    S_TH_WAIT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_model;
    logic load_total;
    logic clear;
    logic rd_row_item;
    logic add_word;
    logic rd_pos;
    logic rd_row_pos;
    logic dec_old;
    logic rd_model;
    logic div_word;
    logic div_theta;
    logic mul;
    logic acc;
    logic thr;
    logic scan;
    logic add_new;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       div_done;
    logic       last_topic;
    logic       scan_hit;
  } dp_sts_t;

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

endpackage

// ----- rtl/core/ldags_div.sv -----
// Restoring divider, one quotient bit a cycle: q = min((num<<16)/den, 2^32-1).
// A zero divisor is taken as one. Depends on ldags_pkg.
module ldags_div
  import ldags_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [WT_W-1:0]  q,
  output logic             done
);

  logic             busy_r, busy_nxt;
  logic             chk_r, chk_nxt;
  logic             done_r, done_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [WT_W-1:0]  lo_r, lo_nxt;
  logic [WT_W-1:0]  q_r, q_nxt;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic             ovf;

  assign trial = {rem_r, lo_r[WT_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  // quotient reaches 2^32 exactly when num >= den<<16
  assign ovf   = {{(DEN_W+FRAC-NUM_W){1'b0}}, num_r} >= {den_r, {FRAC{1'b0}}};

  always_comb begin
    busy_nxt = busy_r;
    chk_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    if (chk_r) begin
      if (ovf) begin
        q_nxt    = '1;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        rem_nxt = DEN_W'(num_r >> FRAC);
        lo_nxt  = {num_r[FRAC-1:0], {(WT_W-FRAC){1'b0}}};
        cnt_nxt = 5'(WT_W - 1);
      end
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      lo_nxt  = {lo_r[WT_W-2:0], 1'b0};
      q_nxt   = {q_r[WT_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
    if (start) begin
      busy_nxt = 1'b1;
      chk_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      chk_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      chk_r  <= chk_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
    if (start) begin
      num_r <= num;
      den_r <= (den == '0) ? DEN_W'(1) : den;
    end
  end

  assign q    = q_r;
  assign done = done_r;

endmodule

// ----- rtl/core/ldags_dp.sv -----
// Datapath: model and sentence stores, weight arithmetic, draw and result register.
// Depends on ldags_pkg and ldags_div; driven by ldags_ctrl commands.
module ldags_dp
  import ldags_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_item,
  input  logic [FIX_W-1:0] alpha,
  input  logic [FIX_W-1:0] beta,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  output out_item_t        out_item
);

  logic [MODEL_W-1:0] mwt_mem [VOCABULARY*TOPICS];
  logic [TOTAL_W-1:0] ttot_mem [TOPICS];
  pos_ent_t           pos_mem [MAX_WORDS];
  row_t               row_mem [MAX_WORDS];

  in_item_t           item_r;
  logic [MODEL_W-1:0] mwt_rd_r;
  logic [TOTAL_W-1:0] ttot_rd_r;
  pos_ent_t           pos_rd_r;
  row_t               row_rd_r;
  logic               row_v_r;
  logic [MAX_WORDS-1:0] row_vld_r;
  row_t               row_r;
  logic [TOPICS-1:0][CNT_W-1:0] doc_r;
  logic [CNT_W-1:0]   tot_r;
  logic [WORD_W-1:0]  w_r;
  logic [POS_W-1:0]   loc_r;
  logic [TOPIC_W-1:0] oldt_r;
  logic [TOPIC_W-1:0] k_r;
  logic [TOPIC_W-1:0] newt_r;
  logic [WT_W-1:0]    acc_r;
  logic [WT_W-1:0]    cum_r [TOPICS];
  logic [WT_W-1:0]    thr_r;
  logic [PROD_W-1:0]  prod_r;
  logic               theta_zero_r;
  out_item_t          out_r;

  row_t               eff_row;
  logic [NUM_W-1:0]   w_num, t_num, d_num;
  logic [DEN_W-1:0]   w_den, t_den, d_den;
  logic [WT_W-1:0]    div_q;
  logic               div_done;
  logic [DFAC_W-1:0]  dfac;
  logic [PROD_W-FRAC-1:0] wt_full;
  logic [WT_W-1:0]    wt;
  logic [WT_W:0]      sum;
  logic [WT_W-1:0]    acc_nxt;
  logic [WT_W+FRAC-1:0] thr_prod;
  logic [THETA_W-1:0] theta;
  logic               hit;
  logic [MODEL_W-1:0] load_val;
  row_t               row_wr;
  logic [POS_W-1:0]   row_wa;

  function automatic row_t row_bump(input row_t r, input logic [TOPIC_W-1:0] t,
                                    input logic up);
    row_t o;
    o    = r;
    o[t] = up ? cnt_inc(r[t]) : cnt_dec(r[t]);
    return o;
  endfunction

  assign eff_row  = row_v_r ? row_rd_r : '0;
  assign load_val = (|item_r.count[TOTAL_W-1:MODEL_W]) ? '1 : item_r.count[MODEL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
  end

  // model stores
  always_ff @(posedge clk) begin
    if (cmd.load_model) mwt_mem[{item_r.word_id, item_r.topic}] <= load_val;
    if (cmd.load_total) ttot_mem[item_r.topic] <= item_r.count;
    if (cmd.rd_model) begin
      mwt_rd_r  <= mwt_mem[{w_r, k_r}];
      ttot_rd_r <= ttot_mem[k_r];
    end
  end

  // position store
  always_ff @(posedge clk) begin
    if (cmd.add_word)
      pos_mem[item_r.position] <= '{topic: item_r.topic, word: item_r.word_id,
                                    loc: item_r.local_word};
    else if (cmd.add_new)
      pos_mem[item_r.position] <= '{topic: newt_r, word: w_r, loc: loc_r};
    if (cmd.rd_pos) pos_rd_r <= pos_mem[item_r.position];
  end

  // sentence rows: an invalid row reads as zero
  always_comb begin
    row_wr = row_bump(row_r, newt_r, 1'b1);
    row_wa = loc_r;
    if (cmd.add_word) begin
      row_wr = row_bump(eff_row, item_r.topic, 1'b1);
      row_wa = item_r.local_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_word || cmd.add_new) row_mem[row_wa] <= row_wr;
    if (cmd.rd_row_item) row_rd_r <= row_mem[item_r.local_word];
    else if (cmd.rd_row_pos) row_rd_r <= row_mem[pos_rd_r.loc];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      row_v_r   <= 1'b0;
      doc_r     <= '0;
      tot_r     <= '0;
    end else begin
      if (cmd.rd_row_item) row_v_r <= row_vld_r[item_r.local_word];
      else if (cmd.rd_row_pos) row_v_r <= row_vld_r[pos_rd_r.loc];
      if (cmd.clear) begin
        row_vld_r <= '0;
        doc_r     <= '0;
        tot_r     <= '0;
      end else if (cmd.add_word) begin
        row_vld_r[item_r.local_word] <= 1'b1;
        doc_r[item_r.topic] <= cnt_inc(doc_r[item_r.topic]);
        tot_r <= cnt_inc(tot_r);
      end else if (cmd.dec_old) begin
        doc_r[oldt_r] <= cnt_dec(doc_r[oldt_r]);
        tot_r <= cnt_dec(tot_r);
      end else if (cmd.add_new) begin
        row_vld_r[loc_r] <= 1'b1;
        doc_r[newt_r] <= cnt_inc(doc_r[newt_r]);
        tot_r <= cnt_inc(tot_r);
      end
    end
  end

  // divider operands
  assign w_num = ((NUM_W'(mwt_rd_r) + NUM_W'(row_r[k_r])) << FRAC) + NUM_W'(beta);
  assign w_den = ((DEN_W'(ttot_rd_r) + DEN_W'(doc_r[k_r])) << FRAC)
               + DEN_W'(beta) * DEN_W'(VOCABULARY);
  assign t_num = (NUM_W'(doc_r[item_r.topic]) << FRAC) + NUM_W'(alpha);
  assign t_den = (DEN_W'(tot_r) << FRAC) + DEN_W'(alpha) * DEN_W'(TOPICS);
  assign d_num = cmd.div_theta ? t_num : w_num;
  assign d_den = cmd.div_theta ? t_den : w_den;

  ldags_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_word | cmd.div_theta),
    .num   (d_num),
    .den   (d_den),
    .q     (div_q),
    .done  (div_done)
  );

  assign dfac     = (DFAC_W'(doc_r[k_r]) << FRAC) + DFAC_W'(alpha);
  assign wt_full  = prod_r[PROD_W-1:FRAC];
  assign wt       = (|wt_full[PROD_W-FRAC-1:WT_W]) ? '1 : wt_full[WT_W-1:0];
  assign sum      = (WT_W+1)'(acc_r) + (WT_W+1)'(wt);
  assign acc_nxt  = sum[WT_W] ? '1 : sum[WT_W-1:0];
  assign thr_prod = (WT_W+FRAC)'(cum_r[TOPICS-1]) * (WT_W+FRAC)'(item_r.random_u);
  assign hit      = (cum_r[k_r] > thr_r) || (k_r == TOPIC_W'(TOPICS-1));
  assign theta    = theta_zero_r ? '0
                  : ((|div_q[WT_W-1:THETA_W]) ? '1 : div_q[THETA_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.rd_row_pos) begin
      w_r    <= pos_rd_r.word;
      loc_r  <= pos_rd_r.loc;
      oldt_r <= pos_rd_r.topic;
    end
    if (cmd.dec_old) begin
      row_r <= row_bump(eff_row, oldt_r, 1'b0);
      k_r   <= '0;
      acc_r <= '0;
    end
    if (cmd.div_theta) theta_zero_r <= (t_den == '0);
    if (cmd.mul) prod_r <= PROD_W'(div_q) * PROD_W'(dfac);
    if (cmd.acc) begin
      acc_r      <= acc_nxt;
      cum_r[k_r] <= acc_nxt;
      k_r        <= k_r + 1'b1;
    end
    if (cmd.thr) begin
      thr_r <= thr_prod[WT_W+FRAC-1:FRAC];
      k_r   <= '0;
    end
    if (cmd.scan) begin
      if (hit) newt_r <= k_r;
      else k_r <= k_r + 1'b1;
    end
    if (cmd.out_load) begin
      if (item_r.kind == KIND_THETA)
        out_r <= '{new_topic: '0, theta_q16: theta, is_theta: 1'b1};
      else
        out_r <= '{new_topic: newt_r, theta_q16: '0, is_theta: 1'b0};
    end
  end

  assign sts.kind       = item_r.kind;
  assign sts.div_done   = div_done;
  assign sts.last_topic = (k_r == TOPIC_W'(TOPICS-1));
  assign sts.scan_hit   = hit;
  assign out_item       = out_r;

endmodule

// ----- rtl/core/ldags_ctrl.sv -----
// Sequencer for the sampler: steps each item's operations and owns the handshakes.
// Depends on ldags_pkg; commands ldags_dp.
module ldags_ctrl
  import ldags_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_nxt = S_IDLE;
        unique case (sts.kind)
          KIND_LOAD_COUNT: cmd.load_model = 1'b1;
          KIND_LOAD_TOTAL: cmd.load_total = 1'b1;
          KIND_ADD: begin
            cmd.rd_row_item = 1'b1;
            state_nxt       = S_ADD_WR;
          end
          KIND_RESAMPLE: begin
            cmd.rd_pos = 1'b1;
            state_nxt  = S_RS_ROW;
          end
          KIND_THETA: begin
            cmd.div_theta = 1'b1;
            state_nxt     = S_TH_WAIT;
          end
          KIND_CLEAR: cmd.clear = 1'b1;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ADD_WR: begin
        cmd.add_word = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_RS_ROW: begin
        cmd.rd_row_pos = 1'b1;
        state_nxt      = S_RS_DEC;
      end
      S_RS_DEC: begin
        cmd.dec_old = 1'b1;
        state_nxt   = S_RS_RD;
      end
      S_RS_RD: begin
        cmd.rd_model = 1'b1;
        state_nxt    = S_RS_DIV;
      end
      S_RS_DIV: begin
        cmd.div_word = 1'b1;
        state_nxt    = S_RS_WAIT;
      end
      S_RS_WAIT: begin
        if (sts.div_done) state_nxt = S_RS_MUL;
      end
      S_RS_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_RS_ACC;
      end
      S_RS_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last_topic ? S_RS_THR : S_RS_RD;
      end
      S_RS_THR: begin
        cmd.thr   = 1'b1;
        state_nxt = S_RS_SCAN;
      end
      S_RS_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit) state_nxt = S_RS_ADD;
      end
      S_RS_ADD: begin
        cmd.add_new = 1'b1;
        state_nxt   = S_RESULT;
      end
      S_TH_WAIT: begin
        if (sts.div_done) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/lda_gibbs_topic_sampler_top.sv -----
// LDA topic sampler top: loads and adds need no divide, theta waits on one divide, and a
// resample runs the 16 topics in turn, each paced by the bit-serial divider, then a draw
// scan over up to 16 topics; a saturating divide finishes early.
// One item in flight at a time; a finished result waits in the output register
// while the next item is taken. Synchronous active-low reset clears control,
// the sentence counts and row-valid bits, and sets alpha 1.0 and beta 0.01;
// model stores and positions are undefined until written.
// Depends on ldags_pkg, ldags_ctrl and ldags_dp.
module lda_gibbs_topic_sampler_top
  import ldags_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [FIX_W-1:0] alpha_r, beta_r;
  logic             wr_en;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= FIX_W'(65536);
      beta_r  <= FIX_W'(655);
    end else if (wr_en) begin
      if (paddr[2]) beta_r <= pwdata[FIX_W-1:0];
      else alpha_r <= pwdata[FIX_W-1:0];
    end
  end

  assign prdata = paddr[2] ? {{(32-FIX_W){1'b0}}, beta_r} : {{(32-FIX_W){1'b0}}, alpha_r};

  ldags_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ldags_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_data),
    .alpha    (alpha_r),
    .beta     (beta_r),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_data)
  );

endmodule

// ----- bench/tb_lda_gibbs_topic_sampler_top.sv -----
// Self-checking bench for the LDA Gibbs topic sampler: random and directed items,
// an in-bench predictor of counts, weights and draws, APB register writes per phase.
// Depends on ldags_pkg and lda_gibbs_topic_sampler_top.
module tb_lda_gibbs_topic_sampler_top;
  import ldags_pkg::*;

  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;
  localparam logic [2:0] ADDR_ALPHA   = 3'd0;
  localparam logic [2:0] ADDR_BETA    = 3'd4;
  localparam int         SETTLE       = 700;

  typedef struct {
    in_item_t item;
    bit       drain;
  } pend_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  lda_gibbs_topic_sampler_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // sampler state as predicted
  logic [23:0] mdl_cnt [VOCABULARY*TOPICS];
  logic [31:0] mdl_tot [TOPICS];
  logic [6:0]  snt_cnt [MAX_WORDS*TOPICS];
  logic [6:0]  doc_cnt [TOPICS];
  logic [6:0]  doc_tot;
  logic [3:0]  pos_top [MAX_WORDS];
  logic [11:0] pos_wrd [MAX_WORDS];
  logic [5:0]  pos_loc [MAX_WORDS];
  logic [23:0] alpha, beta;

  pend_t     pend_q[$];
  out_item_t draw_q[$];
  int n_in, n_err;
  bit in_fire_q;
  int hold_cnt;
  bit hold_done;

  function automatic logic [6:0] sat_up(logic [6:0] v);
    return (v == 7'h7f) ? v : v + 7'd1;
  endfunction

  function automatic logic [6:0] sat_dn(logic [6:0] v);
    return (v == 7'h00) ? v : v - 7'd1;
  endfunction

  function automatic void tally(logic [5:0] l, logic [3:0] t, bit up);
    if (up) begin
      snt_cnt[{l, t}] = sat_up(snt_cnt[{l, t}]);
      doc_cnt[t] = sat_up(doc_cnt[t]);
      doc_tot = sat_up(doc_tot);
    end else begin
      snt_cnt[{l, t}] = sat_dn(snt_cnt[{l, t}]);
      doc_cnt[t] = sat_dn(doc_cnt[t]);
      doc_tot = sat_dn(doc_tot);
    end
  endfunction

  function automatic void clear_sentence();
    foreach (snt_cnt[i]) snt_cnt[i] = '0;
    foreach (doc_cnt[i]) doc_cnt[i] = '0;
    doc_tot = '0;
  endfunction

  function automatic logic [3:0] draw_topic(logic [5:0] p, logic [15:0] u);
    logic [63:0] num, den, ratio, wt, acc, thr, d;
    logic [31:0] cum [TOPICS];
    logic [11:0] w;
    logic [5:0] l;
    logic [3:0] pick;
    bit found;
    w = pos_wrd[p];
    l = pos_loc[p];
    tally(l, pos_top[p], 0);
    acc = 0;
    for (int k = 0; k < TOPICS; k++) begin
      d = doc_cnt[k];
      num = ((64'(mdl_cnt[{w, 4'(k)}]) + 64'(snt_cnt[{l, 4'(k)}])) << 16) + beta;
      den = ((64'(mdl_tot[k]) + d) << 16) + 64'(VOCABULARY) * beta;
      if (den == 0) den = 1;
      ratio = (num << 16) / den;
      if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
      wt = (ratio * ((d << 16) + alpha)) >> 16;
      if (wt > 64'hFFFF_FFFF) wt = 64'hFFFF_FFFF;
      acc = acc + wt;
      if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
      cum[k] = acc[31:0];
    end
    thr = (64'(cum[TOPICS-1]) * u) >> 16;
    pick = 4'(TOPICS - 1);
    found = 0;
    for (int k = 0; k < TOPICS; k++)
      if (!found && 64'(cum[k]) > thr) begin
        pick = 4'(k);
        found = 1;
      end
    tally(l, pick, 1);
    pos_top[p] = pick;
    return pick;
  endfunction

  function automatic logic [15:0] theta_of(logic [3:0] t);
    logic [63:0] num, den, q;
    num = (64'(doc_cnt[t]) << 16) + alpha;
    den = (64'(doc_tot) << 16) + 64'(TOPICS) * alpha;
    if (den == 0) return 16'd0;
    q = (num << 16) / den;
    return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  // apply one accepted item; returns 1 when a result is due
  function automatic bit apply_item(in_item_t it, output out_item_t r);
    r = '0;
    case (it.kind)
      KIND_LOAD_COUNT: mdl_cnt[{it.word_id, it.topic}] =
          (it.count > 32'h00FF_FFFF) ? 24'hFF_FFFF : it.count[23:0];
      KIND_LOAD_TOTAL: mdl_tot[it.topic] = it.count;
      KIND_ADD: begin
        pos_top[it.position] = it.topic;
        pos_wrd[it.position] = it.word_id;
        pos_loc[it.position] = it.local_word;
        tally(it.local_word, it.topic, 1);
      end
      KIND_RESAMPLE: begin
        r.new_topic = draw_topic(it.position, it.random_u);
        return 1;
      end
      KIND_THETA: begin
        r.theta_q16 = theta_of(it.topic);
        r.is_theta = 1'b1;
        return 1;
      end
      KIND_CLEAR: clear_sentence();
      default: ;
    endcase
    return 0;
  endfunction

  // monitor: predict on input items, check result items
  always @(posedge clk) begin
    out_item_t r, want;
    if (!rst_n) begin
      in_fire_q <= 1'b0;
    end else begin
      in_fire_q <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        n_in = n_in + 1;
        if (apply_item(in_data, r)) draw_q.push_back(r);
      end
      if (out_valid && out_ready) begin
        if (draw_q.size() == 0) begin
          n_err = n_err + 1;
          if (n_err <= 10) $display("unexpected result item %p", out_data);
        end else begin
          want = draw_q.pop_front();
          if (out_data.new_topic !== want.new_topic || out_data.theta_q16 !== want.theta_q16
              || out_data.is_theta !== want.is_theta) begin
            n_err = n_err + 1;
            if (n_err <= 10)
              $display("mismatch: expected topic %0d theta %0d is_theta %0d, got %0d %0d %0d",
                       want.new_topic, want.theta_q16, want.is_theta,
                       out_data.new_topic, out_data.theta_q16, out_data.is_theta);
          end
        end
      end
    end
  end

  function automatic bit quiet();
    return n_in >= 900 && n_in < 1100;
  endfunction

  // driver: hold an item until taken, then advance or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire_q) begin
      if (pend_q.size() == 0 || (!quiet() && $urandom_range(99) < 30) ||
          (pend_q[0].drain && draw_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_data <= pend_q[0].item;
        in_valid <= 1'b1;
        void'(pend_q.pop_front());
      end
    end
  end

  // receiver: random stalls, one long hold-off once 300 items have been accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_in >= 300) begin
      hold_cnt <= 3000;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet() || ($urandom_range(99) >= 30);
    end
  end

  logic [11:0] words[$];
  bit pos_set[MAX_WORDS];

  function automatic in_item_t noise();
    in_item_t it;
    it.kind = KIND_CLEAR;
    it.word_id = 12'($urandom);
    it.local_word = 6'($urandom);
    it.position = 6'($urandom);
    it.topic = 4'($urandom);
    it.count = $urandom;
    it.random_u = 16'($urandom);
    return it;
  endfunction

  task automatic send(in_item_t it, bit drain = 0);
    pend_t p;
    p.item = it;
    p.drain = drain;
    pend_q.push_back(p);
  endtask

  task automatic load_word(logic [11:0] w);
    in_item_t it;
    for (int t = 0; t < TOPICS; t++) begin
      it = noise();
      it.kind = KIND_LOAD_COUNT;
      it.word_id = w;
      it.topic = 4'(t);
      it.count = ($urandom_range(9) == 0) ? $urandom : $urandom_range(200);
      send(it);
    end
    words.push_back(w);
  endtask

  task automatic add_word(logic [11:0] w, logic [5:0] p, logic [5:0] l, logic [3:0] t);
    in_item_t it;
    it = noise();
    it.kind = KIND_ADD;
    it.word_id = w;
    it.position = p;
    it.local_word = l;
    it.topic = t;
    send(it);
    pos_set[p] = 1;
  endtask

  task automatic resample_at(logic [5:0] p, logic [15:0] u);
    in_item_t it;
    it = noise();
    it.kind = KIND_RESAMPLE;
    it.position = p;
    it.random_u = u;
    send(it);
  endtask

  task automatic pick_pos(output logic [5:0] p);
    do p = 6'($urandom); while (!pos_set[p]);
  endtask

  task automatic random_phase(int n, int clear_pct);
    in_item_t it;
    logic [5:0] p;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      it = noise();
      if (i == n / 2) begin
        it.kind = KIND_THETA;
        send(it, 1);
      end else if (r < 8) begin
        it.kind = KIND_LOAD_COUNT;
        it.word_id = words[$urandom_range(words.size() - 1)];
        if ($urandom_range(3) != 0) it.count = $urandom_range(300);
        send(it);
      end else if (r < 12) begin
        it.kind = KIND_LOAD_TOTAL;
        if ($urandom_range(3) != 0) it.count = $urandom_range(5000);
        send(it);
      end else if (r < 40) begin
        add_word(words[$urandom_range(words.size() - 1)], 6'($urandom), 6'($urandom),
                 4'($urandom));
      end else if (r < 72) begin
        pick_pos(p);
        resample_at(p, 16'($urandom));
      end else if (r < 95 - clear_pct) begin
        it.kind = KIND_THETA;
        send(it);
      end else if (r < 95) begin
        it.kind = KIND_CLEAR;
        send(it);
      end else if (r < 98) begin
        it.kind = (r[0]) ? KIND_SPARE_A : KIND_SPARE_B;
        send(it);
      end else begin
        it.kind = KIND_LOAD_COUNT;
        it.word_id = 12'($urandom);
        send(it);
        words.push_back(it.word_id);
        load_word(it.word_id);
      end
    end
  endtask

  task automatic reg_write(logic [2:0] a, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= a; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == ADDR_ALPHA) alpha = v[23:0];
    else beta = v[23:0];
  endtask

  task automatic drain_all();
    wait (pend_q.size() == 0 && !in_valid && draw_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic directed();
    in_item_t it;
    it = noise();
    it.kind = KIND_LOAD_COUNT;
    it.word_id = 12'hFFF;
    it.topic = 4'hF;
    it.count = 32'hFFFF_FFFF;
    send(it);
    it.topic = 4'h0;
    it.count = 32'h0100_0000;
    send(it);
    it.kind = KIND_LOAD_TOTAL;
    it.topic = 4'hF;
    it.count = 32'hFFFF_FFFF;
    send(it);
    it.count = 32'd0;
    it.topic = 4'h0;
    send(it);
    add_word(12'h000, 6'd0, 6'd0, 4'd0);
    add_word(12'hFFF, 6'd63, 6'd63, 4'd15);
    resample_at(6'd0, 16'h0000);
    resample_at(6'd63, 16'hFFFF);
    resample_at(6'd0, 16'hFFFF);
    it = noise();
    it.kind = KIND_THETA;
    it.topic = 4'd0;
    send(it);
    it.topic = 4'd15;
    send(it);
    it.kind = KIND_SPARE_A;
    send(it);
    it.kind = KIND_SPARE_B;
    send(it);
    it.kind = KIND_CLEAR;
    send(it);
    it.kind = KIND_THETA;
    send(it);
    resample_at(6'd63, 16'h8000);
    // add eight words to local word 5 under topic 3
    for (int i = 0; i < 8; i++) add_word(12'h000, 6'(i + 1), 6'd5, 4'd3);
  endtask

  initial begin
    in_item_t it;
    n_in = 0;
    n_err = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    alpha = 24'd65536;
    beta = 24'd655;
    foreach (mdl_cnt[i]) mdl_cnt[i] = '0;
    foreach (mdl_tot[i]) mdl_tot[i] = '0;
    foreach (pos_top[i]) begin
      pos_top[i] = '0; pos_wrd[i] = '0; pos_loc[i] = '0; pos_set[i] = 0;
    end
    clear_sentence();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int t = 0; t < TOPICS; t++) begin
      it = noise();
      it.kind = KIND_LOAD_TOTAL;
      it.topic = 4'(t);
      it.count = $urandom_range(4000);
      send(it);
    end
    load_word(12'h000);
    load_word(12'hFFF);
    for (int i = 0; i < 8; i++) load_word(12'($urandom));
    directed();
    for (int i = 0; i < 140; i++) add_word(12'hFFF, 6'd62, 6'd1, 4'd7);
    resample_at(6'd62, 16'($urandom));
    random_phase(250, 3);
    drain_all();

    reg_write(ADDR_ALPHA, 32'd1);
    reg_write(ADDR_BETA, 32'd1);
    random_phase(250, 1);
    drain_all();

    reg_write(ADDR_ALPHA, 32'h00FF_FFFF);
    reg_write(ADDR_BETA, 32'h00FF_FFFF);
    random_phase(250, 3);
    drain_all();

    reg_write(ADDR_ALPHA, $urandom);
    reg_write(ADDR_BETA, $urandom_range(20000, 1));
    random_phase(250, 2);
    drain_all();

    if (n_err == 0 && draw_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
